FILE: hdl/afmc_pkg.sv
package afmc_pkg;

    // Flight mode codes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_NORMAL = 2'd1;
    localparam logic [1:0] MODE_FIX    = 2'd2;
    localparam logic [1:0] MODE_FAIL   = 2'd3;

    // Arming phase codes
    localparam logic [2:0] ARM_FREE      = 3'd0;
    localparam logic [2:0] ARM_HIGH      = 3'd1;
    localparam logic [2:0] ARM_LEFT_HIGH = 3'd2;
    localparam logic [2:0] ARM_LOW       = 3'd3;
    localparam logic [2:0] ARM_UNLOCKED  = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_ARM_HIGH    = 2'd0;
    localparam logic [1:0] CFG_ARM_LOW     = 2'd1;
    localparam logic [1:0] CFG_HOLD_TICKS  = 2'd2;
    localparam logic [1:0] CFG_MAX_RETRIES = 2'd3;

    // Configuration reset values
    localparam logic [15:0] ARM_HIGH_RST    = 16'd900;
    localparam logic [15:0] ARM_LOW_RST     = 16'd100;
    localparam logic [31:0] HOLD_TICKS_RST  = 32'd1000;
    localparam logic [7:0]  MAX_RETRIES_RST = 8'd3;

    // Toggle request code carried in the fix-height field
    localparam logic [7:0] TOGGLE_REQ = 8'd1;

    typedef struct packed {
        logic [15:0] arm_high_throttle;
        logic [15:0] arm_low_throttle;
        logic [31:0] hold_ticks;
        logic [7:0]  max_retries;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  mode;
        logic        link_up;
        logic [7:0]  fail_count;
        logic [2:0]  arm;
        logic [31:0] high_start_tick;
        logic [31:0] low_start_tick;
        logic [15:0] held_throttle;
        logic [7:0]  held_toggle;
    } t_state;

    // Poll fields as taken from the input register
    typedef struct packed {
        logic        rx_ok;
        logic [15:0] throttle;
        logic [7:0]  fix_height_request;
        logic [31:0] tick_now;
    } t_poll;

endpackage

FILE: hdl/arming_and_flight_mode_controller.sv
// Arming and flight mode controller. Each input beat is one control poll;
// each poll gives exactly one result beat with the flight mode, link status
// and arming phase after that poll's update. A poll is registered on entry
// and its state update is done as it moves on, when the result is
// registered; one poll can be taken every cycle unless the result register
// is full and stalled. Input stall rises only when a held poll cannot move
// because the result register is full and stalled. Configuration writes
// take effect at once and are meant to be made while no poll is in flight.
module arming_and_flight_mode_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // poll channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_rx_ok,
    input  logic [15:0] i_throttle,
    input  logic [7:0]  i_fix_height_request,
    input  logic [31:0] i_tick_now,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_flight_mode,
    output logic        o_link_connected,
    output logic [2:0]  o_arm_phase,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    logic              r_in_vld;
    afmc_pkg::t_poll   r_poll;
    logic              r_out_vld;
    logic [1:0]        r_mode_out;
    logic              r_link_out;
    logic [2:0]        r_arm_out;
    afmc_pkg::t_cfg    r_cfg;
    afmc_pkg::t_state  r_state;
    afmc_pkg::t_state  n_state;
    logic              move;
    logic              in_take;

    // handshake
    assign move       = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !move;
    assign in_take    = i_in_valid && !o_in_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.arm_high_throttle <= afmc_pkg::ARM_HIGH_RST;
            r_cfg.arm_low_throttle  <= afmc_pkg::ARM_LOW_RST;
            r_cfg.hold_ticks        <= afmc_pkg::HOLD_TICKS_RST;
            r_cfg.max_retries       <= afmc_pkg::MAX_RETRIES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                afmc_pkg::CFG_ARM_HIGH:    r_cfg.arm_high_throttle <= i_cfg_data[15:0];
                afmc_pkg::CFG_ARM_LOW:     r_cfg.arm_low_throttle  <= i_cfg_data[15:0];
                afmc_pkg::CFG_HOLD_TICKS:  r_cfg.hold_ticks        <= i_cfg_data;
                afmc_pkg::CFG_MAX_RETRIES: r_cfg.max_retries       <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (move) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_poll.rx_ok              <= i_rx_ok;
            r_poll.throttle           <= i_throttle;
            r_poll.fix_height_request <= i_fix_height_request;
            r_poll.tick_now           <= i_tick_now;
        end
    end

    // next-state logic
    afmc_step u_step (
        .i_cfg  (r_cfg),
        .i_cur  (r_state),
        .i_poll (r_poll),
        .o_nxt  (n_state)
    );

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode            <= afmc_pkg::MODE_IDLE;
            r_state.link_up         <= 1'b0;
            r_state.fail_count      <= 8'd0;
            r_state.arm             <= afmc_pkg::ARM_FREE;
            r_state.high_start_tick <= 32'd0;
            r_state.low_start_tick  <= 32'd0;
            r_state.held_throttle   <= 16'd0;
            r_state.held_toggle     <= 8'd0;
        end else if (move) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (move) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_mode_out <= n_state.mode;
            r_link_out <= n_state.link_up;
            r_arm_out  <= n_state.arm;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_flight_mode    = r_mode_out;
    assign o_link_connected = r_link_out;
    assign o_arm_phase      = r_arm_out;

endmodule

FILE: hdl/afmc_step.sv
module afmc_step (
    input  afmc_pkg::t_cfg   i_cfg,
    input  afmc_pkg::t_state i_cur,
    input  afmc_pkg::t_poll  i_poll,
    output afmc_pkg::t_state o_nxt
);

    logic [7:0]  fail_inc;
    logic [31:0] high_elapsed;
    logic [31:0] low_elapsed;
    logic [15:0] thr;
    afmc_pkg::t_state s;

    assign fail_inc     = i_cur.fail_count + 8'd1;
    assign thr          = i_poll.rx_ok ? i_poll.throttle : i_cur.held_throttle;
    assign high_elapsed = i_poll.tick_now - i_cur.high_start_tick;
    assign low_elapsed  = i_poll.tick_now - i_cur.low_start_tick;

    always_comb begin
        s = i_cur;

        // latch received frame
        if (i_poll.rx_ok) begin
            s.held_throttle = i_poll.throttle;
            s.held_toggle   = i_poll.fix_height_request;
        end

        // link tracker
        if (i_poll.rx_ok) begin
            s.link_up    = 1'b1;
            s.fail_count = 8'd0;
        end else if (fail_inc >= i_cfg.max_retries) begin
            s.link_up    = 1'b0;
            s.fail_count = 8'd0;
        end else begin
            s.fail_count = fail_inc;
        end

        // mode machine, arming sequence runs only in idle
        case (i_cur.mode)
            afmc_pkg::MODE_IDLE: begin
                case (i_cur.arm)
                    afmc_pkg::ARM_FREE: begin
                        if (thr >= i_cfg.arm_high_throttle) begin
                            s.arm             = afmc_pkg::ARM_HIGH;
                            s.high_start_tick = i_poll.tick_now;
                        end
                    end
                    afmc_pkg::ARM_HIGH: begin
                        if (thr < i_cfg.arm_high_throttle) begin
                            s.arm = (high_elapsed >= i_cfg.hold_ticks) ?
                                    afmc_pkg::ARM_LEFT_HIGH : afmc_pkg::ARM_FREE;
                        end
                    end
                    afmc_pkg::ARM_LEFT_HIGH: begin
                        if (thr <= i_cfg.arm_low_throttle) begin
                            s.arm            = afmc_pkg::ARM_LOW;
                            s.low_start_tick = i_poll.tick_now;
                        end
                    end
                    afmc_pkg::ARM_LOW: begin
                        if (thr > i_cfg.arm_low_throttle) begin
                            s.arm = afmc_pkg::ARM_FREE;
                        end else if (low_elapsed >= i_cfg.hold_ticks) begin
                            s.arm = afmc_pkg::ARM_UNLOCKED;
                        end
                    end
                    default: ;
                endcase
                // unlock goes straight to normal with the phase back at free
                if (s.arm == afmc_pkg::ARM_UNLOCKED) begin
                    s.mode = afmc_pkg::MODE_NORMAL;
                    s.arm  = afmc_pkg::ARM_FREE;
                end
            end
            afmc_pkg::MODE_NORMAL, afmc_pkg::MODE_FIX: begin
                if (s.held_toggle == afmc_pkg::TOGGLE_REQ) begin
                    s.mode        = (i_cur.mode == afmc_pkg::MODE_NORMAL) ?
                                    afmc_pkg::MODE_FIX : afmc_pkg::MODE_NORMAL;
                    s.held_toggle = 8'd0;
                end
                // link loss wins over a toggle in the same poll
                if (!s.link_up) begin
                    s.mode = afmc_pkg::MODE_FAIL;
                end
            end
            default: begin
                if (s.link_up) begin
                    s.mode = afmc_pkg::MODE_IDLE;
                end
            end
        endcase
    end

    assign o_nxt = s;

endmodule

FILE: bench/arming_and_flight_mode_controller_test.sv
`timescale 1ns / 1ps

module arming_and_flight_mode_controller_test;

    localparam int QUIET_LIMIT = 5000;
    localparam int SEGMENT_POLLS = 340;

    // Status seen at the output after one poll
    typedef struct packed {
        logic [1:0] mode;
        logic       link;
        logic [2:0] arm;
    } t_flight_status;

    logic             i_clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             out_stall = 1'b0;
    logic             cfg_we = 1'b0;
    logic [1:0]       cfg_idx = afmc_pkg::CFG_ARM_HIGH;
    logic [31:0]      cfg_data = 32'd0;
    afmc_pkg::t_poll  beat = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_flight_mode;
    logic        o_link_connected;
    logic [2:0]  o_arm_phase;

    // Predictor copy of the controller
    afmc_pkg::t_state model_state;
    afmc_pkg::t_cfg   model_cfg;

    afmc_pkg::t_poll pending_polls[$];
    t_flight_status  due_status[$];

    int          send_idle_pct = 38;
    int          recv_stall_pct = 61;
    int          error_count = 0;
    int          quiet_cycles = 0;
    int          queued_polls = 0;
    logic [31:0] tick_clock = 32'd0;

    arming_and_flight_mode_controller uut (
        .i_clk                (i_clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .o_in_stall           (o_in_stall),
        .i_rx_ok              (beat.rx_ok),
        .i_throttle           (beat.throttle),
        .i_fix_height_request (beat.fix_height_request),
        .i_tick_now           (beat.tick_now),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (out_stall),
        .o_flight_mode        (o_flight_mode),
        .o_link_connected     (o_link_connected),
        .o_arm_phase          (o_arm_phase),
        .i_cfg_we             (cfg_we),
        .i_cfg_idx            (cfg_idx),
        .i_cfg_data           (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag_error(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // One control poll: latch, link tracker, then mode machine
    function automatic t_flight_status advance_controller(afmc_pkg::t_poll p);
        logic [15:0]    thr;
        t_flight_status res;
        if (p.rx_ok) begin
            model_state.held_throttle = p.throttle;
            model_state.held_toggle = p.fix_height_request;
            model_state.link_up = 1'b1;
            model_state.fail_count = 8'd0;
        end else begin
            model_state.fail_count = model_state.fail_count + 8'd1;
            if (model_state.fail_count >= model_cfg.max_retries) begin
                model_state.link_up = 1'b0;
                model_state.fail_count = 8'd0;
            end
        end
        thr = model_state.held_throttle;
        case (model_state.mode)
            afmc_pkg::MODE_IDLE: begin
                // arming sequence, elapsed ticks wrap modulo 2^32
                case (model_state.arm)
                    afmc_pkg::ARM_FREE: begin
                        if (thr >= model_cfg.arm_high_throttle) begin
                            model_state.arm = afmc_pkg::ARM_HIGH;
                            model_state.high_start_tick = p.tick_now;
                        end
                    end
                    afmc_pkg::ARM_HIGH: begin
                        if (thr < model_cfg.arm_high_throttle) begin
                            if (p.tick_now - model_state.high_start_tick >=
                                model_cfg.hold_ticks)
                                model_state.arm = afmc_pkg::ARM_LEFT_HIGH;
                            else
                                model_state.arm = afmc_pkg::ARM_FREE;
                        end
                    end
                    afmc_pkg::ARM_LEFT_HIGH: begin
                        if (thr <= model_cfg.arm_low_throttle) begin
                            model_state.arm = afmc_pkg::ARM_LOW;
                            model_state.low_start_tick = p.tick_now;
                        end
                    end
                    afmc_pkg::ARM_LOW: begin
                        if (thr > model_cfg.arm_low_throttle)
                            model_state.arm = afmc_pkg::ARM_FREE;
                        else if (p.tick_now - model_state.low_start_tick >=
                                 model_cfg.hold_ticks)
                            model_state.arm = afmc_pkg::ARM_UNLOCKED;
                    end
                    default: ;
                endcase
                if (model_state.arm == afmc_pkg::ARM_UNLOCKED) begin
                    model_state.mode = afmc_pkg::MODE_NORMAL;
                    model_state.arm = afmc_pkg::ARM_FREE;
                end
            end
            afmc_pkg::MODE_NORMAL, afmc_pkg::MODE_FIX: begin
                if (model_state.held_toggle == afmc_pkg::TOGGLE_REQ) begin
                    model_state.mode = (model_state.mode == afmc_pkg::MODE_NORMAL) ?
                                       afmc_pkg::MODE_FIX : afmc_pkg::MODE_NORMAL;
                    model_state.held_toggle = 8'd0;
                end
                // loss wins over a toggle in the same poll
                if (!model_state.link_up)
                    model_state.mode = afmc_pkg::MODE_FAIL;
            end
            default: begin
                if (model_state.link_up)
                    model_state.mode = afmc_pkg::MODE_IDLE;
            end
        endcase
        res.mode = model_state.mode;
        res.link = model_state.link_up;
        res.arm = model_state.arm;
        return res;
    endfunction

    // Driver: feeds poll beats from the pending queue
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall)
                due_status.push_back(advance_controller(beat));
            if (!in_valid || !o_in_stall) begin
                if (pending_polls.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    beat <= pending_polls.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks result beats against the predicted status
    always @(posedge i_clk) begin
        t_flight_status want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid === 1'b1 && !out_stall) begin
                if (due_status.size() == 0) begin
                    flag_error("result beat with no poll outstanding");
                end else begin
                    want = due_status.pop_front();
                    if (o_flight_mode !== want.mode)
                        flag_error($sformatf("flight_mode %0d, want %0d",
                                             o_flight_mode, want.mode));
                    if (o_link_connected !== want.link)
                        flag_error($sformatf("link_connected %0d, want %0d",
                                             o_link_connected, want.link));
                    if (o_arm_phase !== want.arm)
                        flag_error($sformatf("arm_phase %0d, want %0d",
                                             o_arm_phase, want.arm));
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid === 1'b1 && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("arming_and_flight_mode_controller_test: FAIL");
        $finish;
    end

    task automatic add_poll(logic ok, logic [15:0] thr, logic [7:0] fix, logic [31:0] tick);
        afmc_pkg::t_poll p;
        p.rx_ok = ok;
        p.throttle = thr;
        p.fix_height_request = fix;
        p.tick_now = tick;
        pending_polls.push_back(p);
        queued_polls++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            afmc_pkg::CFG_ARM_HIGH:    model_cfg.arm_high_throttle = val[15:0];
            afmc_pkg::CFG_ARM_LOW:     model_cfg.arm_low_throttle = val[15:0];
            afmc_pkg::CFG_HOLD_TICKS:  model_cfg.hold_ticks = val;
            afmc_pkg::CFG_MAX_RETRIES: model_cfg.max_retries = val[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic [15:0] hi, logic [15:0] lo, logic [31:0] hold,
                                  logic [7:0] retries);
        write_reg(afmc_pkg::CFG_ARM_HIGH, {16'd0, hi});
        write_reg(afmc_pkg::CFG_ARM_LOW, {16'd0, lo});
        write_reg(afmc_pkg::CFG_HOLD_TICKS, hold);
        write_reg(afmc_pkg::CFG_MAX_RETRIES, {24'd0, retries});
    endtask

    // Wait until every poll is sent and every result is back
    task automatic drain();
        do @(negedge i_clk);
        while (pending_polls.size() != 0 || in_valid || due_status.size() != 0);
    endtask

    function automatic logic [15:0] high_throttle();
        if ($urandom_range(3) == 0)
            return model_cfg.arm_high_throttle;
        return 16'($urandom_range(65535, model_cfg.arm_high_throttle));
    endfunction

    function automatic logic [15:0] low_throttle();
        if ($urandom_range(3) == 0)
            return model_cfg.arm_low_throttle;
        return 16'($urandom_range(model_cfg.arm_low_throttle, 0));
    endfunction

    function automatic logic [7:0] fix_value();
        case ($urandom_range(3))
            0, 1:    return afmc_pkg::TOGGLE_REQ;
            2:       return 8'd0;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Gap that lands on or just around the hold time
    function automatic logic [31:0] hold_gap();
        if ($urandom_range(9) < 2)
            return model_cfg.hold_ticks - 32'd1;
        return model_cfg.hold_ticks + $urandom_range(2);
    endfunction

    // Arming run, some flying with toggles, maybe a link loss, then noise
    task automatic queue_flight();
        int n;
        if ($urandom_range(4) == 0)
            tick_clock = 32'hFFFF_FFF0 + $urandom_range(15);
        tick_clock += $urandom_range(3);
        add_poll(1'b1, high_throttle(), fix_value(), tick_clock);
        n = $urandom_range(2);
        repeat (n) begin
            tick_clock += $urandom_range(3);
            add_poll(1'b1, high_throttle(), fix_value(), tick_clock);
        end
        tick_clock += hold_gap();
        add_poll(1'b1, high_throttle(), fix_value(), tick_clock);
        add_poll(1'b1, low_throttle(), fix_value(), tick_clock);
        tick_clock += $urandom_range(3);
        add_poll(1'b1, low_throttle(), fix_value(), tick_clock);
        tick_clock += hold_gap();
        add_poll(1'b1, low_throttle(), fix_value(), tick_clock);

        n = $urandom_range(12, 2);
        repeat (n) begin
            tick_clock += $urandom_range(50);
            add_poll($urandom_range(9) != 0, 16'($urandom_range(65535)), fix_value(),
                     tick_clock);
        end

        if ($urandom_range(99) < ((model_cfg.max_retries > 20) ? 5 : 50)) begin
            n = (model_cfg.max_retries == 0) ? 1 : int'(model_cfg.max_retries);
            repeat (n) add_poll(1'b0, 16'($urandom_range(65535)), 8'($urandom_range(255)),
                                tick_clock);
            add_poll(1'b1, low_throttle(), fix_value(), tick_clock);
        end

        n = $urandom_range(3);
        repeat (n) begin
            if ($urandom_range(2) == 0)
                tick_clock = $urandom;
            else
                tick_clock += $urandom_range(1000);
            add_poll(1'($urandom_range(1)), 16'($urandom_range(65535)),
                     8'($urandom_range(255)), tick_clock);
        end
    endtask

    // Directed polls at the reset settings (900 / 100 / 1000 / 3)
    task automatic queue_directed();
        add_poll(1'b1, 16'd0, 8'd0, 32'd0);
        // arming across the tick wrap
        add_poll(1'b1, 16'hFFFF, 8'hFF, 32'hFFFF_FF00);
        add_poll(1'b1, 16'd900, 8'd0, 32'h0000_02E8);
        add_poll(1'b1, 16'd899, 8'd0, 32'h0000_02E8);
        // toggle latched in idle stays held
        add_poll(1'b1, 16'd100, afmc_pkg::TOGGLE_REQ, 32'h0000_02E8);
        add_poll(1'b0, 16'hFFFF, 8'd0, 32'h0000_06CF);
        // unlock on a failed poll, then loss with a held toggle
        add_poll(1'b0, 16'd0, 8'd0, 32'h0000_06D0);
        add_poll(1'b0, 16'd0, 8'd0, 32'h0000_06D0);
        add_poll(1'b0, 16'd0, 8'd0, 32'h0000_06D1);
        add_poll(1'b1, 16'd0, afmc_pkg::TOGGLE_REQ, 32'h0000_06D2);
        // high phase released too early
        add_poll(1'b1, 16'hFFFF, 8'd0, 32'h0000_1000);
        add_poll(1'b1, 16'd0, 8'd0, 32'h0000_13E7);
        // low phase broken by throttle above the low limit
        add_poll(1'b1, 16'd1000, 8'd0, 32'h0000_2000);
        add_poll(1'b1, 16'd500, 8'd0, 32'h0000_23E8);
        add_poll(1'b1, 16'd101, 8'd0, 32'h0000_23E8);
        add_poll(1'b1, 16'd0, 8'd0, 32'h0000_23E9);
        add_poll(1'b1, 16'd101, 8'd0, 32'h0000_23EA);
        // full arming, then fix-height toggles
        add_poll(1'b1, 16'hFFFF, 8'd0, 32'h0000_5000);
        add_poll(1'b1, 16'd0, 8'd0, 32'h0001_4FFF);
        add_poll(1'b1, 16'd0, afmc_pkg::TOGGLE_REQ, 32'h0001_4FFF);
        add_poll(1'b1, 16'd0, afmc_pkg::TOGGLE_REQ, 32'h0001_53E7);
        add_poll(1'b1, 16'd0, afmc_pkg::TOGGLE_REQ, 32'h0001_53E8);
        add_poll(1'b1, 16'd0, afmc_pkg::TOGGLE_REQ, 32'h0001_53E9);
        add_poll(1'b1, 16'd0, 8'd2, 32'hFFFF_FFFF);
        add_poll(1'b0, 16'd0, 8'd0, 32'hFFFF_FFFF);
    endtask

    initial begin
        int          seg;
        int          goal;
        logic [15:0] hi;
        model_cfg.arm_high_throttle = afmc_pkg::ARM_HIGH_RST;
        model_cfg.arm_low_throttle = afmc_pkg::ARM_LOW_RST;
        model_cfg.hold_ticks = afmc_pkg::HOLD_TICKS_RST;
        model_cfg.max_retries = afmc_pkg::MAX_RETRIES_RST;
        model_state = '0;
        model_state.mode = afmc_pkg::MODE_IDLE;
        model_state.arm = afmc_pkg::ARM_FREE;

        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;

        queue_directed();
        drain();

        for (seg = 0; seg < 6; seg++) begin
            if (seg == 2) begin
                send_idle_pct = 61;
                recv_stall_pct = 38;
            end
            if (seg == 4) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            case (seg)
                1: apply_settings(16'd0, 16'hFFFF, 32'd0, 8'd0);
                3: apply_settings(16'hFFFF, 16'd0, 32'hFFFF_FFFF, 8'd255);
                default: begin
                    hi = 16'($urandom_range(2000, 200));
                    apply_settings(hi, 16'($urandom_range(hi - 16'd1, 0)),
                                   ($urandom_range(4) == 0) ? $urandom : $urandom_range(40),
                                   8'($urandom_range(6, 1)));
                end
            endcase
            goal = queued_polls + SEGMENT_POLLS;
            while (queued_polls < goal)
                queue_flight();
            drain();
        end

        repeat (6) @(posedge i_clk);
        if (error_count == 0)
            $display("arming_and_flight_mode_controller_test: PASS");
        else
            $display("arming_and_flight_mode_controller_test: FAIL");
        $finish;
    end

endmodule

FILE: arming_and_flight_mode_controller.f
hdl/afmc_pkg.sv
hdl/afmc_step.sv
hdl/arming_and_flight_mode_controller.sv
bench/arming_and_flight_mode_controller_test.sv
